// ===== rtl/pswi_pkg.sv =====
// ----------------------------------------------------------------------------
// pswi_pkg
// Shared types and constants for the windowed-integral PID step unit.
// ----------------------------------------------------------------------------
package pswi_pkg;

   localparam int DataWidth  = 32;
   localparam int ClampWidth = 31;
   localparam int ErrWidth   = 33;
   localparam int SumWidth   = 35;
   localparam int DiffWidth  = 34;
   localparam int TermWidth  = 50;
   localparam int AccWidth   = 52;
   localparam int IndexWidth = 3;

   localparam logic [IndexWidth-1:0] CSR_KP_GAIN   = 3'd0;
   localparam logic [IndexWidth-1:0] CSR_KI_GAIN   = 3'd1;
   localparam logic [IndexWidth-1:0] CSR_KD_GAIN   = 3'd2;
   localparam logic [IndexWidth-1:0] CSR_OUT_LIMIT = 3'd3;
   localparam logic [IndexWidth-1:0] CSR_SUM_LIMIT = 3'd4;

   localparam logic CMD_STEP  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef struct packed {
      logic signed [DataWidth-1:0] kp_gain;
      logic signed [DataWidth-1:0] ki_gain;
      logic signed [DataWidth-1:0] kd_gain;
      logic [ClampWidth-1:0]       out_limit;
      logic [ClampWidth-1:0]       sum_limit;
   } cfg_type;

   typedef struct packed {
      logic                        clear;
      logic signed [ErrWidth-1:0]  err;
      logic signed [DataWidth-1:0] sum;
      logic signed [DiffWidth-1:0] diff;
   } entry_type;

endpackage

// ===== rtl/pswi_front.sv =====
// ----------------------------------------------------------------------------
// pswi_front
// Accepts requests, forms error, clamped window sum and difference, and keeps
// the two-deep error history.
// ----------------------------------------------------------------------------
module pswi_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic signed [pswi_pkg::DataWidth-1:0] req_reference,
   input  logic signed [pswi_pkg::DataWidth-1:0] req_feedback,
   input  logic [pswi_pkg::ClampWidth-1:0]       sum_limit,
   input  logic                                  q_full,
   output logic                                  push,
   output pswi_pkg::entry_type                   push_entry
);

   logic signed [pswi_pkg::ErrWidth-1:0]  error_last_ff, error_last_in;
   logic signed [pswi_pkg::ErrWidth-1:0]  error_before_last_ff, error_before_last_in;
   logic signed [pswi_pkg::ErrWidth-1:0]  err;
   logic signed [pswi_pkg::SumWidth-1:0]  sum_raw;
   logic signed [pswi_pkg::SumWidth-1:0]  sum_max;
   logic signed [pswi_pkg::SumWidth-1:0]  sum_min;
   logic signed [pswi_pkg::SumWidth-1:0]  sum_clamped;
   logic signed [pswi_pkg::DiffWidth-1:0] diff;

   assign req_stall = q_full;
   assign push      = req_valid && !req_stall;

   always_comb begin
      err = pswi_pkg::ErrWidth'(req_reference) - pswi_pkg::ErrWidth'(req_feedback);
      sum_raw = pswi_pkg::SumWidth'(err) + pswi_pkg::SumWidth'(error_last_ff)
              + pswi_pkg::SumWidth'(error_before_last_ff);
      diff = pswi_pkg::DiffWidth'(err) - pswi_pkg::DiffWidth'(error_last_ff);
      sum_max = $signed({4'b0000, sum_limit});
      sum_min = -sum_max;
      if (sum_raw >= sum_max) begin
         sum_clamped = sum_max;
      end else if (sum_raw <= sum_min) begin
         sum_clamped = sum_min;
      end else begin
         sum_clamped = sum_raw;
      end
      push_entry.clear = (req_cmd == pswi_pkg::CMD_CLEAR);
      push_entry.err   = err;
      push_entry.sum   = sum_clamped[pswi_pkg::DataWidth-1:0];
      push_entry.diff  = diff;
      if (req_cmd == pswi_pkg::CMD_CLEAR) begin
         error_last_in        = '0;
         error_before_last_in = '0;
      end else begin
         error_last_in        = err;
         error_before_last_in = error_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_last_ff        <= '0;
         error_before_last_ff <= '0;
      end else if (push) begin
         error_last_ff        <= error_last_in;
         error_before_last_ff <= error_before_last_in;
      end
   end

   a_clear_history: assert property (@(posedge clock) disable iff (reset)
      (push && req_cmd == pswi_pkg::CMD_CLEAR) |=>
         (error_last_ff == '0 && error_before_last_ff == '0))
      else $error("history not cleared");

   a_history_shift: assert property (@(posedge clock) disable iff (reset)
      (push && req_cmd == pswi_pkg::CMD_STEP) |=>
         (error_before_last_ff == $past(error_last_ff)))
      else $error("history did not shift");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push)
      else $error("push while queue full");

endmodule

// ===== rtl/pswi_queue.sv =====
// ----------------------------------------------------------------------------
// pswi_queue
// Short FIFO between the front and back halves.
// ----------------------------------------------------------------------------
module pswi_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pswi_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                q_valid,
   output logic                q_full,
   output pswi_pkg::entry_type q_head
);

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);

   pswi_pkg::entry_type         mem_ff [DEPTH];
   logic [PtrWidth-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]       count_ff, count_in;

   assign q_valid = (count_ff != '0);
   assign q_full  = (count_ff == CountWidth'(DEPTH));
   assign q_head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(DEPTH))
      else $error("queue count overflow");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("pop from empty queue");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow");

endmodule

// ===== rtl/pswi_back.sv =====
// ----------------------------------------------------------------------------
// pswi_back
// Gain multiplies, term sum, output clamp and the response register.
// ----------------------------------------------------------------------------
module pswi_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pswi_pkg::cfg_type                     cfg,
   input  logic                                  q_valid,
   input  pswi_pkg::entry_type                   q_head,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [pswi_pkg::DataWidth-1:0] rsp_drive
);

   localparam int PadWidth = pswi_pkg::AccWidth - pswi_pkg::ClampWidth;

   logic                                  m_valid_ff;
   logic                                  m_clear_ff;
   logic signed [pswi_pkg::TermWidth-1:0] t_kp_ff, t_kp_in;
   logic signed [pswi_pkg::TermWidth-1:0] t_ki_ff, t_ki_in;
   logic signed [pswi_pkg::TermWidth-1:0] t_kd_ff, t_kd_in;
   logic signed [64:0]                    p_kp;
   logic signed [63:0]                    p_ki;
   logic signed [65:0]                    p_kd;
   logic signed [pswi_pkg::AccWidth-1:0]  acc;
   logic signed [pswi_pkg::AccWidth-1:0]  out_max;
   logic signed [pswi_pkg::AccWidth-1:0]  out_min;
   logic signed [pswi_pkg::AccWidth-1:0]  acc_clamped;
   logic signed [pswi_pkg::DataWidth-1:0] rsp_drive_ff, rsp_drive_in;
   logic                                  rsp_valid_ff;
   logic                                  m_en;
   logic                                  out_en;

   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign m_en      = !m_valid_ff || out_en;
   assign pop       = q_valid && m_en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   always_comb begin
      p_kp    = 65'(cfg.kp_gain) * 65'(q_head.err);
      p_ki    = 64'(cfg.ki_gain) * 64'(q_head.sum);
      p_kd    = 66'(cfg.kd_gain) * 66'(q_head.diff);
      t_kp_in = pswi_pkg::TermWidth'(p_kp >>> 16);
      t_ki_in = pswi_pkg::TermWidth'(p_ki >>> 16);
      t_kd_in = pswi_pkg::TermWidth'(p_kd >>> 16);
   end

   always_comb begin
      acc = pswi_pkg::AccWidth'(t_kp_ff) + pswi_pkg::AccWidth'(t_ki_ff)
          + pswi_pkg::AccWidth'(t_kd_ff);
      out_max = $signed({{PadWidth{1'b0}}, cfg.out_limit});
      out_min = -out_max;
      if (acc > out_max) begin
         acc_clamped = out_max;
      end else if (acc < out_min) begin
         acc_clamped = out_min;
      end else begin
         acc_clamped = acc;
      end
      rsp_drive_in = m_clear_ff ? '0 : acc_clamped[pswi_pkg::DataWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (m_en) begin
            m_valid_ff <= q_valid;
         end
         if (out_en) begin
            rsp_valid_ff <= m_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         m_clear_ff <= q_head.clear;
         t_kp_ff    <= t_kp_in;
         t_ki_ff    <= t_ki_in;
         t_kd_ff    <= t_kd_in;
      end
      if (out_en && m_valid_ff) begin
         rsp_drive_ff <= rsp_drive_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !m_valid_ff))
      else $error("pipeline valid after reset");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (out_en && m_valid_ff && m_clear_ff) |=> (rsp_drive_ff == '0))
      else $error("clear did not give zero drive");

   a_pipe_advance: assert property (@(posedge clock) disable iff (reset)
      (m_valid_ff && out_en) |=> rsp_valid_ff)
      else $error("product stage lost an item");

endmodule

// ===== rtl/pid_step_windowed_integral_unit.sv =====
// ----------------------------------------------------------------------------
// pid_step_windowed_integral_unit
// PID step with a three-sample error window and clamped Q16.16 output.
// ----------------------------------------------------------------------------
// One request per clock is accepted while req_stall is low, and one response
// per request is returned, in order. A request enters the front stage, which
// computes the error, the clamped window sum and the difference and updates
// the error history in the cycle it is accepted; it then waits in a FIFO of
// QUEUE_DEPTH entries. The back stage runs the three gain multipliers in one
// registered pass and sums and clamps in the next. Sustained throughput is
// one request per cycle while rsp_stall is low, set by the single pass
// through the multiplier stage. A clear request (cmd = 1) zeroes the history
// and answers drive = 0. The user must write registers through the csr_ port
// only while no request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module pid_step_windowed_integral_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic signed [pswi_pkg::DataWidth-1:0] req_reference,
   input  logic signed [pswi_pkg::DataWidth-1:0] req_feedback,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [pswi_pkg::DataWidth-1:0] rsp_drive,
   input  logic                                  csr_write,
   input  logic [pswi_pkg::IndexWidth-1:0]       csr_index,
   input  logic [pswi_pkg::DataWidth-1:0]        csr_data
);

   pswi_pkg::cfg_type   cfg_ff;
   pswi_pkg::entry_type push_entry;
   pswi_pkg::entry_type q_head;
   logic                push;
   logic                pop;
   logic                q_valid;
   logic                q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            pswi_pkg::CSR_KP_GAIN:   cfg_ff.kp_gain   <= $signed(csr_data);
            pswi_pkg::CSR_KI_GAIN:   cfg_ff.ki_gain   <= $signed(csr_data);
            pswi_pkg::CSR_KD_GAIN:   cfg_ff.kd_gain   <= $signed(csr_data);
            pswi_pkg::CSR_OUT_LIMIT: cfg_ff.out_limit <= csr_data[pswi_pkg::ClampWidth-1:0];
            pswi_pkg::CSR_SUM_LIMIT: cfg_ff.sum_limit <= csr_data[pswi_pkg::ClampWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   pswi_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_reference (req_reference),
      .req_feedback  (req_feedback),
      .sum_limit     (cfg_ff.sum_limit),
      .q_full        (q_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   pswi_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_full     (q_full),
      .q_head     (q_head)
   );

   pswi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_drive (rsp_drive)
   );

endmodule
